### src/sarst_pkg.sv
// ----------------------------------------------------------------------------
// sarst_pkg
// Shared types and constants for the moving average and running statistics
// block.
// ----------------------------------------------------------------------------
package sarst_pkg;

	localparam int DATA_W         = 32;
	localparam int DIV_W          = 64;
	localparam int SQRT_IN_W      = 64;
	localparam int SQRT_OUT_W     = SQRT_IN_W / 2;
	localparam int CFG_ADDR_W     = 4;
	localparam int WINDOW_MAX_DEF = 256;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int RATE_SCALE     = 1000000;
	localparam int RATE_SCALE_W   = 20;

	typedef enum logic [1:0] {
		REQ_SAMPLE    = 2'd0,
		REQ_CLR_HIST  = 2'd1,
		REQ_CLR_STATS = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		DSEL_AVG   = 3'd0,
		DSEL_RATIO = 3'd1,
		DSEL_MEAN  = 3'd2,
		DSEL_VAR   = 3'd3,
		DSEL_RATE  = 3'd4
	} div_sel_t;

	typedef struct packed {
		logic     latch_in;
		logic     clr_hist;
		logic     clr_stats;
		logic     prune_rd;
		logic     prune_sub;
		logic     win_wr;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_take;
		logic     stats_begin;
		logic     stats_first;
		logic     mul_prep;
		logic     mul_step;
		logic     m2_upd;
		logic     sqrt_start;
		logic     sqrt_take;
		logic     stats_fill;
		logic     load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		req_t req;
		logic need_prune;
		logic div_done;
		logic ratio_ok;
		logic stats_en;
		logic cnt_one;
		logic elapsed_nz;
		logic mul_last;
		logic sqrt_done;
		logic out_free;
	} dp_status_t;

endpackage

### src/sarst_ram.sv
// ----------------------------------------------------------------------------
// sarst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sarst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/sarst_div.sv
// ----------------------------------------------------------------------------
// sarst_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sarst_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sarst_pkg::DIV_W-1:0] num,
	input  logic [sarst_pkg::DIV_W-1:0] den,
	output logic                       done,
	output logic [sarst_pkg::DIV_W-1:0] quo
);
	import sarst_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0] n_q;
	logic [DIV_W-1:0] d_q;
	logic [DIV_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, n_q[DIV_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			n_q   <= {n_q[DIV_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = n_q;

endmodule

### src/sarst_sqrt.sv
// ----------------------------------------------------------------------------
// sarst_sqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module sarst_sqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [sarst_pkg::SQRT_IN_W-1:0] radicand,
	output logic                            done,
	output logic [sarst_pkg::SQRT_OUT_W-1:0] root
);
	import sarst_pkg::*;

	localparam int CNT_W = $clog2(SQRT_OUT_W);
	localparam int REM_W = SQRT_OUT_W + 2;

	logic [SQRT_IN_W-1:0]  x_q;
	logic [SQRT_OUT_W-1:0] root_q;
	logic [REM_W-1:0]      rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [REM_W+1:0]      r_sh;
	logic [REM_W+1:0]      r_try;
	logic                  fits;

	assign r_sh  = {rem_q, x_q[SQRT_IN_W-1 -: 2]};
	assign r_try = (REM_W+2)'({root_q, 2'b01});
	assign fits  = r_sh >= r_try;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SQRT_OUT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[SQRT_IN_W-3:0], 2'b00};
			rem_q  <= fits ? REM_W'(r_sh - r_try) : REM_W'(r_sh);
			root_q <= {root_q[SQRT_OUT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### src/sarst_ctrl.sv
// ----------------------------------------------------------------------------
// sarst_ctrl
// Sequencer: steps the datapath through clear requests, history update,
// averaging, ratio, Welford statistics and rate for one transaction at a time.
// ----------------------------------------------------------------------------
module sarst_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  sarst_pkg::dp_status_t  status,
	output sarst_pkg::ctrl_cmd_t   cmd
);
	import sarst_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_PRUNE_RD,
		S_PRUNE_SUB,
		S_WRITE,
		S_AVG_GO,
		S_AVG_WAIT,
		S_RATIO_GO,
		S_RATIO_WAIT,
		S_STATS,
		S_SPLIT,
		S_MEAN_WAIT,
		S_MUL_PREP,
		S_MUL,
		S_M2,
		S_VAR_GO,
		S_VAR_WAIT,
		S_SQRT_GO,
		S_SQRT_WAIT,
		S_RATE_GO,
		S_RATE_WAIT,
		S_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.div_sel = DSEL_AVG;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				case (status.req)
					REQ_SAMPLE: begin
						state_d = S_PRUNE_RD;
					end
					REQ_CLR_HIST: begin
						cmd.clr_hist = 1'b1;
						state_d      = S_OUT;
					end
					REQ_CLR_STATS: begin
						cmd.clr_stats = 1'b1;
						state_d       = S_OUT;
					end
					default: begin
						state_d = S_OUT;
					end
				endcase
			end
			S_PRUNE_RD: begin
				if (status.need_prune) begin
					cmd.prune_rd = 1'b1;
					state_d      = S_PRUNE_SUB;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_PRUNE_SUB: begin
				cmd.prune_sub = 1'b1;
				state_d       = S_PRUNE_RD;
			end
			S_WRITE: begin
				cmd.win_wr = 1'b1;
				state_d    = S_AVG_GO;
			end
			S_AVG_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_AVG;
				state_d       = S_AVG_WAIT;
			end
			S_AVG_WAIT: begin
				if (status.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = S_RATIO_GO;
				end
			end
			S_RATIO_GO: begin
				if (status.ratio_ok) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_RATIO;
					state_d       = S_RATIO_WAIT;
				end else begin
					state_d = S_STATS;
				end
			end
			S_RATIO_WAIT: begin
				if (status.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = S_STATS;
				end
			end
			S_STATS: begin
				if (status.stats_en) begin
					cmd.stats_begin = 1'b1;
					state_d         = S_SPLIT;
				end else begin
					state_d = S_OUT;
				end
			end
			S_SPLIT: begin
				if (status.cnt_one) begin
					cmd.stats_first = 1'b1;
					state_d         = S_RATE_GO;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_MEAN;
					state_d       = S_MEAN_WAIT;
				end
			end
			S_MEAN_WAIT: begin
				if (status.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = S_MUL_PREP;
				end
			end
			S_MUL_PREP: begin
				cmd.mul_prep = 1'b1;
				state_d      = S_MUL;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (status.mul_last) begin
					state_d = S_M2;
				end
			end
			S_M2: begin
				cmd.m2_upd = 1'b1;
				state_d    = S_VAR_GO;
			end
			S_VAR_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_VAR;
				state_d       = S_VAR_WAIT;
			end
			S_VAR_WAIT: begin
				if (status.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = S_SQRT_GO;
				end
			end
			S_SQRT_GO: begin
				cmd.sqrt_start = 1'b1;
				state_d        = S_SQRT_WAIT;
			end
			S_SQRT_WAIT: begin
				if (status.sqrt_done) begin
					cmd.sqrt_take = 1'b1;
					state_d       = S_RATE_GO;
				end
			end
			S_RATE_GO: begin
				cmd.stats_fill = 1'b1;
				if (status.elapsed_nz) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_RATE;
					state_d       = S_RATE_WAIT;
				end else begin
					state_d = S_OUT;
				end
			end
			S_RATE_WAIT: begin
				if (status.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = S_OUT;
				end
			end
			S_OUT: begin
				// hold until the output register is free
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/sarst_datapath.sv
// ----------------------------------------------------------------------------
// sarst_datapath
// Window ring, sums, Welford registers, shared divider and square root,
// result and output registers.
// ----------------------------------------------------------------------------
module sarst_datapath #(
	parameter int WINDOW_MAX = sarst_pkg::WINDOW_MAX_DEF,
	parameter int FRAC_BITS  = sarst_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sarst_pkg::ctrl_cmd_t               cmd,
	output sarst_pkg::dp_status_t              status,
	input  logic [1:0]                         req_type,
	input  logic signed [31:0]                 sample_value,
	input  logic [31:0]                        time_ms,
	input  logic [$clog2(WINDOW_MAX+1)-1:0]    win_len,
	input  logic                               win_len_wr,
	input  logic [$clog2(WINDOW_MAX+1)-1:0]    win_cur,
	input  logic signed [31:0]                 ref_low,
	input  logic signed [31:0]                 ref_high,
	input  logic                               stats_en,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [31:0]                 avg_value,
	output logic [FRAC_BITS:0]                 range_ratio,
	output logic                               stats_valid,
	output logic signed [31:0]                 mean_value,
	output logic [31:0]                        std_dev,
	output logic signed [31:0]                 sample_min,
	output logic signed [31:0]                 sample_max,
	output logic [31:0]                        sample_count,
	output logic [31:0]                        rate_millihz,
	output logic [31:0]                        event_time
);
	import sarst_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_MAX);
	localparam int WL_W  = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W = DATA_W + IDX_W + 1;
	localparam int RD_W  = IDX_W + 2;
	localparam logic [DIV_W-1:0] RATIO_ONE = DIV_W'(1) << FRAC_BITS;

	// latched transaction
	logic signed [31:0] x_q;
	logic [31:0]        time_q;
	logic [1:0]         req_q;

	// history
	logic [IDX_W-1:0]        wp_q;
	logic [WL_W-1:0]         fill_q;
	logic [WL_W-1:0]         lim_q;
	logic signed [SUM_W-1:0] sum_q;

	// statistics
	logic [31:0]        cnt_q;
	logic signed [31:0] mean_q;
	logic [63:0]        m2_q;
	logic signed [31:0] min_q;
	logic signed [31:0] max_q;
	logic [31:0]        start_q;
	logic               seen_q;
	logic [32:0]        dabs_q;
	logic               dneg_q;
	logic [32:0]        d2abs_q;
	logic [63:0]        acc_q;
	logic [1:0]         mstep_q;
	div_sel_t           sel_q;

	// result
	logic signed [31:0] res_avg_q;
	logic [FRAC_BITS:0] res_ratio_q;
	logic               res_sv_q;
	logic signed [31:0] res_mean_q;
	logic [31:0]        res_std_q;
	logic signed [31:0] res_min_q;
	logic signed [31:0] res_max_q;
	logic [31:0]        res_cnt_q;
	logic [31:0]        res_rate_q;
	logic [31:0]        res_time_q;
	logic               out_valid_q;

	logic [WL_W-1:0]        wl_m1;
	logic [WL_W-1:0]        limit;
	logic [RD_W-1:0]        rd_tmp;
	logic [IDX_W-1:0]       rd_idx;
	logic [31:0]            rd_data;
	logic                   sum_neg;
	logic [SUM_W-1:0]       sum_mag;
	logic signed [32:0]     avg_diff;
	logic signed [32:0]     range_w;
	logic signed [32:0]     delta;
	logic signed [32:0]     delta2;
	logic signed [33:0]     mean_new;
	logic [16:0]            mul_a;
	logic [16:0]            mul_b;
	logic [33:0]            pp;
	logic [63:0]            pp_sh;
	logic [64:0]            m2_sum;
	logic [51:0]            rate_prod;
	logic [31:0]            elapsed;
	logic [DIV_W-1:0]       div_num;
	logic [DIV_W-1:0]       div_den;
	logic                   div_done;
	logic [DIV_W-1:0]       div_quo;
	logic                   sqrt_done;
	logic [SQRT_OUT_W-1:0]  sqrt_root;

	// keep room for the new sample and apply any shorter window written since
	assign wl_m1 = win_cur - 1'b1;
	assign limit = (lim_q < wl_m1) ? lim_q : wl_m1;

	// oldest entry sits fill places behind the write pointer
	assign rd_tmp = RD_W'(wp_q) + RD_W'(WINDOW_MAX) - RD_W'(fill_q);
	assign rd_idx = (rd_tmp >= RD_W'(WINDOW_MAX)) ?
		IDX_W'(rd_tmp - RD_W'(WINDOW_MAX)) : IDX_W'(rd_tmp);

	assign sum_neg = sum_q[SUM_W-1];
	assign sum_mag = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	assign avg_diff = {res_avg_q[31], res_avg_q} - {ref_low[31], ref_low};
	assign range_w  = {ref_high[31], ref_high} - {ref_low[31], ref_low};
	assign delta    = {x_q[31], x_q} - {mean_q[31], mean_q};
	assign delta2   = {x_q[31], x_q} - {mean_q[31], mean_q};
	assign mean_new = dneg_q ? ({{2{mean_q[31]}}, mean_q} - 34'(div_quo[32:0])) :
		({{2{mean_q[31]}}, mean_q} + 34'(div_quo[32:0]));

	// one 17x17 partial product per step
	assign mul_a = mstep_q[1] ? {1'b0, dabs_q[32:17]} : dabs_q[16:0];
	assign mul_b = mstep_q[0] ? {1'b0, d2abs_q[32:17]} : d2abs_q[16:0];
	assign pp    = 34'(mul_a) * 34'(mul_b);

	always_comb begin
		case (mstep_q)
			2'd0:    pp_sh = 64'(pp);
			2'd3:    pp_sh = 64'(pp) << 34;
			default: pp_sh = 64'(pp) << 17;
		endcase
	end

	assign m2_sum    = {1'b0, m2_q} + {1'b0, acc_q};
	assign rate_prod = 52'(cnt_q) * 52'(RATE_SCALE);
	assign elapsed   = time_q - start_q;

	always_comb begin
		case (cmd.div_sel)
			DSEL_AVG: begin
				div_num = DIV_W'(sum_mag);
				div_den = DIV_W'(fill_q);
			end
			DSEL_RATIO: begin
				div_num = DIV_W'(avg_diff) << FRAC_BITS;
				div_den = DIV_W'(range_w);
			end
			DSEL_MEAN: begin
				div_num = DIV_W'(delta[32] ? -delta : delta);
				div_den = DIV_W'(cnt_q);
			end
			DSEL_VAR: begin
				div_num = DIV_W'(m2_q);
				div_den = DIV_W'(cnt_q - 32'd1);
			end
			DSEL_RATE: begin
				div_num = DIV_W'(rate_prod);
				div_den = DIV_W'(elapsed);
			end
			default: begin
				div_num = '0;
				div_den = DIV_W'(1);
			end
		endcase
	end

	sarst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	sarst_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (SQRT_IN_W'(div_quo)),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	sarst_ram #(
		.WIDTH (DATA_W),
		.DEPTH (WINDOW_MAX)
	) u_ram (
		.clk   (clk),
		.we    (cmd.win_wr),
		.waddr (wp_q),
		.wdata (x_q),
		.raddr (rd_idx),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			fill_q      <= '0;
			lim_q       <= WL_W'(WINDOW_MAX);
			sum_q       <= '0;
			cnt_q       <= '0;
			mean_q      <= '0;
			m2_q        <= '0;
			min_q       <= '0;
			max_q       <= '0;
			start_q     <= '0;
			seen_q      <= 1'b0;
			mstep_q     <= '0;
			sel_q       <= DSEL_AVG;
			out_valid_q <= 1'b0;
		end else begin
			// a shorter window drops entries on the next sample
			if (win_len_wr && (win_len < lim_q)) begin
				lim_q <= win_len;
			end
			if (cmd.clr_hist) begin
				wp_q   <= '0;
				fill_q <= '0;
				sum_q  <= '0;
			end
			if (cmd.prune_sub) begin
				sum_q  <= sum_q - SUM_W'(signed'(rd_data));
				fill_q <= fill_q - 1'b1;
			end
			if (cmd.win_wr) begin
				wp_q   <= (wp_q == IDX_W'(WINDOW_MAX - 1)) ? '0 : wp_q + 1'b1;
				fill_q <= fill_q + 1'b1;
				sum_q  <= sum_q + SUM_W'(x_q);
				lim_q  <= WL_W'(WINDOW_MAX);
			end
			if (cmd.clr_stats) begin
				cnt_q   <= '0;
				mean_q  <= '0;
				m2_q    <= '0;
				min_q   <= '0;
				max_q   <= '0;
				start_q <= '0;
				seen_q  <= 1'b0;
			end
			if (cmd.stats_begin) begin
				if (!seen_q) begin
					start_q <= time_q;
					seen_q  <= 1'b1;
				end
				if (cnt_q != '1) begin
					cnt_q <= cnt_q + 32'd1;
				end
			end
			if (cmd.stats_first) begin
				mean_q <= x_q;
				m2_q   <= '0;
				min_q  <= x_q;
				max_q  <= x_q;
			end
			if (cmd.div_start) begin
				sel_q <= cmd.div_sel;
			end
			if (cmd.div_take && (sel_q == DSEL_MEAN)) begin
				mean_q <= mean_new[31:0];
			end
			if (cmd.mul_prep) begin
				mstep_q <= '0;
			end else if (cmd.mul_step) begin
				mstep_q <= mstep_q + 1'b1;
			end
			if (cmd.m2_upd) begin
				m2_q <= m2_sum[64] ? '1 : m2_sum[63:0];
				if (x_q < min_q) begin
					min_q <= x_q;
				end
				if (x_q > max_q) begin
					max_q <= x_q;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			x_q         <= sample_value;
			time_q      <= time_ms;
			req_q       <= req_type;
			res_avg_q   <= '0;
			res_ratio_q <= '0;
			res_sv_q    <= 1'b0;
			res_mean_q  <= '0;
			res_std_q   <= '0;
			res_min_q   <= '0;
			res_max_q   <= '0;
			res_cnt_q   <= '0;
			res_rate_q  <= '0;
			res_time_q  <= time_ms;
		end
		if (cmd.clr_stats) begin
			res_sv_q <= 1'b1;
		end
		if (cmd.div_start && (cmd.div_sel == DSEL_MEAN)) begin
			dabs_q <= delta[32] ? 33'(-delta) : 33'(delta);
			dneg_q <= delta[32];
		end
		if (cmd.mul_prep) begin
			d2abs_q <= delta2[32] ? 33'(-delta2) : 33'(delta2);
			acc_q   <= '0;
		end else if (cmd.mul_step) begin
			acc_q <= acc_q + pp_sh;
		end
		if (cmd.div_take) begin
			case (sel_q)
				DSEL_AVG: begin
					res_avg_q <= sum_neg ? -div_quo[31:0] : div_quo[31:0];
				end
				DSEL_RATIO: begin
					res_ratio_q <= (div_quo > RATIO_ONE) ? RATIO_ONE[FRAC_BITS:0] :
						div_quo[FRAC_BITS:0];
				end
				DSEL_RATE: begin
					res_rate_q <= (div_quo[DIV_W-1:32] != '0) ? '1 : div_quo[31:0];
				end
				default: begin
				end
			endcase
		end
		if (cmd.sqrt_take) begin
			res_std_q <= 32'(sqrt_root);
		end
		if (cmd.stats_fill) begin
			res_sv_q   <= 1'b1;
			res_mean_q <= mean_q;
			res_min_q  <= min_q;
			res_max_q  <= max_q;
			res_cnt_q  <= cnt_q;
		end
		if (cmd.load_out) begin
			avg_value    <= res_avg_q;
			range_ratio  <= res_ratio_q;
			stats_valid  <= res_sv_q;
			mean_value   <= res_mean_q;
			std_dev      <= res_std_q;
			sample_min   <= res_min_q;
			sample_max   <= res_max_q;
			sample_count <= res_cnt_q;
			rate_millihz <= res_rate_q;
			event_time   <= res_time_q;
		end
	end

	assign out_valid = out_valid_q;

	assign status.req        = req_t'(req_q);
	assign status.need_prune = fill_q > limit;
	assign status.div_done   = div_done;
	assign status.ratio_ok   = (range_w > 33'sd0) && (avg_diff > 33'sd0);
	assign status.stats_en   = stats_en;
	assign status.cnt_one    = (cnt_q == 32'd1);
	assign status.elapsed_nz = (elapsed != '0);
	assign status.mul_last   = (mstep_q == 2'd3);
	assign status.sqrt_done  = sqrt_done;
	assign status.out_free   = !out_valid_q || !out_stall;

endmodule

### src/sample_average_and_running_stats_top.sv
// ----------------------------------------------------------------------------
// sample_average_and_running_stats_top
// Moving average, reference range ratio and running statistics over Q16.16
// samples, with an APB-style register port.
// ----------------------------------------------------------------------------
// A clear request goes straight to the output. A sample first drops the entries
//   that no longer fit the window, then divides for the average and, when it applies,
//   the ratio; with statistics it updates mean, m2, variance and square root after the
//   first sample and divides for the rate once time has elapsed.
// Throughput: one transaction at a time; the next is taken while a result waits.
// Reset: asynchronous, clears history, statistics and registers to defaults.
module sample_average_and_running_stats_top #(
	parameter int WINDOW_MAX = sarst_pkg::WINDOW_MAX_DEF,
	parameter int FRAC_BITS  = sarst_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [sarst_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           req_type,
	input  logic signed [31:0]                   sample_value,
	input  logic [31:0]                          time_ms,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [31:0]                   avg_value,
	output logic [FRAC_BITS:0]                   range_ratio,
	output logic                                 stats_valid,
	output logic signed [31:0]                   mean_value,
	output logic [31:0]                          std_dev,
	output logic signed [31:0]                   sample_min,
	output logic signed [31:0]                   sample_max,
	output logic [31:0]                          sample_count,
	output logic [31:0]                          rate_millihz,
	output logic [31:0]                          event_time
);
	import sarst_pkg::*;

	localparam int WL_W = $clog2(WINDOW_MAX + 1);

	localparam logic [1:0] REG_WIN_LEN  = 2'd0;
	localparam logic [1:0] REG_REF_LOW  = 2'd1;
	localparam logic [1:0] REG_REF_HIGH = 2'd2;
	localparam logic [1:0] REG_STATS_EN = 2'd3;

	logic [WL_W-1:0]    wl_q;
	logic signed [31:0] low_q;
	logic signed [31:0] high_q;
	logic               sen_q;
	logic               wr;
	logic [1:0]         reg_idx;
	logic [31:0]        wl_raw;
	logic [WL_W-1:0]    wl_new;
	logic               wl_wr;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign wl_raw  = {23'd0, pwdata[8:0]};
	assign wl_new  = (wl_raw == 32'd0) ? WL_W'(1) :
		(wl_raw > 32'(WINDOW_MAX)) ? WL_W'(WINDOW_MAX) : WL_W'(wl_raw);
	assign wl_wr   = wr && (reg_idx == REG_WIN_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q   <= WL_W'(1);
			low_q  <= 32'sd0;
			high_q <= 32'sd6553600;
			sen_q  <= 1'b0;
		end else if (wr) begin
			case (reg_idx)
				REG_WIN_LEN: begin
					wl_q <= wl_new;
				end
				REG_REF_LOW: begin
					// drop a bottom that is not below the top
					if ($signed(pwdata) < high_q) begin
						low_q <= pwdata;
					end
				end
				REG_REF_HIGH: begin
					if ($signed(pwdata) > low_q) begin
						high_q <= pwdata;
					end
				end
				REG_STATS_EN: begin
					sen_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WIN_LEN:  prdata = 32'(wl_q);
			REG_REF_LOW:  prdata = low_q;
			REG_REF_HIGH: prdata = high_q;
			REG_STATS_EN: prdata = {31'd0, sen_q};
			default:      prdata = '0;
		endcase
	end

	sarst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	sarst_datapath #(
		.WINDOW_MAX (WINDOW_MAX),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.req_type     (req_type),
		.sample_value (sample_value),
		.time_ms      (time_ms),
		.win_len      (wl_new),
		.win_len_wr   (wl_wr),
		.win_cur      (wl_q),
		.ref_low      (low_q),
		.ref_high     (high_q),
		.stats_en     (sen_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.avg_value    (avg_value),
		.range_ratio  (range_ratio),
		.stats_valid  (stats_valid),
		.mean_value   (mean_value),
		.std_dev      (std_dev),
		.sample_min   (sample_min),
		.sample_max   (sample_max),
		.sample_count (sample_count),
		.rate_millihz (rate_millihz),
		.event_time   (event_time)
	);

endmodule

### tb/sample_average_and_running_stats_top_tb.sv
// ----------------------------------------------------------------------------
// sample_average_and_running_stats_top_tb
// Drives samples and clear requests through the block under several register
// settings and idle patterns, predicts each result in a local model of the
// window average and running statistics, and compares every field in order.
// ----------------------------------------------------------------------------
module sample_average_and_running_stats_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sarst_pkg::*;

	localparam int WMAX = 256;
	localparam logic [3:0] A_WLEN = 4'd0, A_RLOW = 4'd4, A_RHIGH = 4'd8, A_STATS = 4'd12;

	typedef struct packed {
		logic signed [31:0] avg;
		logic [16:0]        ratio;
		logic               sv;
		logic signed [31:0] mean;
		logic [31:0]        sd;
		logic signed [31:0] mn;
		logic signed [31:0] mx;
		logic [31:0]        cnt;
		logic [31:0]        rate;
		logic [31:0]        evt;
	} stats_res_t;

	logic clk = 1'b0, arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	logic in_valid = 1'b0, in_stall;
	logic [1:0] req_type = '0;
	logic signed [31:0] sample_value = '0;
	logic [31:0] time_ms = '0;
	logic out_valid, out_stall = 1'b0;
	logic signed [31:0] avg_value, mean_value, sample_min, sample_max;
	logic [16:0] range_ratio;
	logic stats_valid;
	logic [31:0] std_dev, sample_count, rate_millihz, event_time;

	sample_average_and_running_stats_top u_top (.*);

	always #1 clk = ~clk;

	// model state
	logic signed [31:0] ring [WMAX];
	int unsigned wpos, fill, wlen, cnt;
	longint wsum;
	logic signed [31:0] rlow, rhigh, rmean, rmin, rmax;
	logic [63:0] m2;
	logic [31:0] t0;
	bit t0_seen, stats_on;

	stats_res_t results_due[$];
	int errors = 0;
	int send_idle = 0, recv_idle = 0;
	bit hold_off = 1'b0;
	logic [31:0] now_ms = 0;

	task automatic report(string what, longint got, longint exp);
		$display("mismatch %s: got %0d expected %0d", what, got, exp);
		errors++;
	endtask

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned r = 0, b = 64'h4000_0000_0000_0000;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void drop_to(int unsigned lim);
		while (fill > lim) begin
			wsum -= ring[(wpos + WMAX - fill) % WMAX];
			fill--;
		end
	endfunction

	function automatic void model_reset();
		wpos = 0; fill = 0; wsum = 0; cnt = 0; rmean = 0; m2 = 0;
		rmin = 0; rmax = 0; t0 = 0; t0_seen = 0;
		wlen = 1; rlow = 0; rhigh = 6553600; stats_on = 0;
	endfunction

	function automatic stats_res_t predict_result(logic [1:0] rq, logic signed [31:0] x,
			logic [31:0] now);
		stats_res_t r = '0;
		longint avg, rng, d, d2;
		longint unsigned a, b, p, q;
		logic [31:0] el;
		r.evt = now;
		if (rq == REQ_CLR_HIST) begin
			wpos = 0; fill = 0; wsum = 0;
			return r;
		end
		if (rq == REQ_CLR_STATS) begin
			cnt = 0; rmean = 0; m2 = 0; rmin = 0; rmax = 0; t0 = 0; t0_seen = 0;
			r.sv = 1;
			return r;
		end
		if (rq == 2'd3) return r;
		drop_to(wlen - 1);
		ring[wpos] = x;
		wpos = (wpos + 1) % WMAX;
		fill++;
		wsum += x;
		avg = wsum / longint'(fill);
		rng = longint'(rhigh) - longint'(rlow);
		r.avg = avg[31:0];
		if (rng > 0 && avg > longint'(rlow)) begin
			q = (unsigned'(avg - longint'(rlow)) << 16) / unsigned'(rng);
			r.ratio = (q > 65536) ? 17'd65536 : q[16:0];
		end
		if (!stats_on) return r;
		if (!t0_seen) begin
			t0 = now; t0_seen = 1;
		end
		if (cnt != 32'hFFFF_FFFF) cnt++;
		if (cnt == 1) begin
			rmean = x; m2 = 0; rmin = x; rmax = x;
		end else begin
			d = longint'(x) - rmean;
			rmean = 32'(longint'(rmean) + d / longint'(cnt));
			d2 = longint'(x) - rmean;
			a = d < 0 ? -d : d;
			b = d2 < 0 ? -d2 : d2;
			p = a * b;
			m2 = (m2 > 64'hFFFF_FFFF_FFFF_FFFF - p) ? 64'hFFFF_FFFF_FFFF_FFFF : m2 + p;
			if (x < rmin) rmin = x;
			if (x > rmax) rmax = x;
		end
		r.sv = 1; r.mean = rmean; r.mn = rmin; r.mx = rmax; r.cnt = cnt;
		if (cnt > 1) r.sd = 32'(isqrt(m2 / 64'(cnt - 1)));
		el = now - t0;
		if (el != 0) begin
			q = 64'(cnt) * 64'd1000000 / 64'(el);
			r.rate = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
		end
		return r;
	endfunction

	task automatic reg_write(logic [3:0] addr, logic [31:0] val);
		int unsigned w;
		logic signed [31:0] v;
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
		v = val;
		case (addr)
			A_WLEN: begin
				w = val[8:0];
				if (w < 1) w = 1;
				if (w > WMAX) w = WMAX;
				wlen = w;
				drop_to(wlen);
			end
			A_RLOW:  if (v < rhigh) rlow = v;
			A_RHIGH: if (v > rlow) rhigh = v;
			A_STATS: stats_on = val[0];
			default: ;
		endcase
	endtask

	task automatic send_item(logic [1:0] rq, logic signed [31:0] x, logic [31:0] t);
		int gap;
		gap = 0;
		if (send_idle > 0)
			while ($urandom_range(99) < send_idle && gap < 20) gap++;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1; req_type <= rq; sample_value <= x; time_ms <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		results_due.push_back(predict_result(rq, x, t));
		in_valid <= 0;
		// the block is busy after a transaction, so drop valid for a cycle
		@(posedge clk);
	endtask

	task automatic send_sample(logic signed [31:0] x);
		now_ms += $urandom_range(40);
		send_item(REQ_SAMPLE, x, now_ms);
	endtask

	task automatic wait_drained();
		while (results_due.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) out_stall <= hold_off || ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		stats_res_t e, g;
		if (arst_n && out_valid && !out_stall) begin
			g = '{avg_value, range_ratio, stats_valid, mean_value, std_dev, sample_min,
				sample_max, sample_count, rate_millihz, event_time};
			if (results_due.size() == 0) begin
				report("unexpected result", 0, 0);
			end else begin
				e = results_due.pop_front();
				if (g.avg !== e.avg) report("avg_value", g.avg, e.avg);
				if (g.ratio !== e.ratio) report("range_ratio", g.ratio, e.ratio);
				if (g.sv !== e.sv) report("stats_valid", g.sv, e.sv);
				if (g.mean !== e.mean) report("mean_value", g.mean, e.mean);
				if (g.sd !== e.sd) report("std_dev", g.sd, e.sd);
				if (g.mn !== e.mn) report("sample_min", g.mn, e.mn);
				if (g.mx !== e.mx) report("sample_max", g.mx, e.mx);
				if (g.cnt !== e.cnt) report("sample_count", g.cnt, e.cnt);
				if (g.rate !== e.rate) report("rate_millihz", g.rate, e.rate);
				if (g.evt !== e.evt) report("event_time", g.evt, e.evt);
			end
		end
	end

	task automatic test_directed();
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000);
		send_item(2'd3, 32'sh1234_5678, 32'hFFFF_FFFF);
		wait_drained();
		reg_write(A_STATS, 32'd1);
		reg_write(A_WLEN, 32'd4);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000);
		send_sample(32'sh0000_0000);
		send_sample(32'sh0010_0000);
		send_item(REQ_SAMPLE, -32'sd1, now_ms);
		send_item(REQ_CLR_HIST, 0, 32'hFFFF_FFFF);
		send_sample(32'sh0006_4000);
		send_item(REQ_CLR_STATS, 32'shFFFF_FFFF, 32'h0);
		send_sample(-32'sd65536);
		send_item(REQ_SAMPLE, 32'sd65536, 32'hFFFF_FFF0);
		send_item(REQ_SAMPLE, 32'sd3, 32'h0000_0005);
		wait_drained();
		reg_write(A_RLOW, 32'h8000_0000);
		reg_write(A_RHIGH, 32'h7FFF_FFFF);
		reg_write(A_RHIGH, 32'h8000_0000);
		send_sample(32'sh8000_0000);
		send_sample(32'sh7FFF_FFFF);
		wait_drained();
		reg_write(A_WLEN, 32'h1FF);
		reg_write(A_WLEN, 32'h0);
		send_sample(32'sd42);
		wait_drained();
	endtask

	task automatic random_phase(int n, int si, int ri);
		int k;
		send_idle = si; recv_idle = ri;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(19))
				0: send_item(REQ_CLR_HIST, $urandom, $urandom);
				1: send_item(REQ_CLR_STATS, $urandom, now_ms);
				2: send_item(2'd3, $urandom, $urandom);
				3, 4: send_sample($urandom);
				default: send_sample($signed($urandom_range(2000000)) - 1000000);
			endcase
		end
		wait_drained();
	endtask

	task automatic test_random();
		reg_write(A_WLEN, 32'd256);
		reg_write(A_RLOW, -32'sd655360);
		reg_write(A_RHIGH, 32'sd655360);
		random_phase(320, 0, 0);
		reg_write(A_WLEN, $urandom_range(2, 16));
		reg_write(A_STATS, 32'd0);
		random_phase(40, 73, 0);
		reg_write(A_STATS, 32'd1);
		reg_write(A_WLEN, 32'd1);
		random_phase(40, 0, 73);
		reg_write(A_WLEN, $urandom_range(1, 300));
		random_phase(40, 15, 15);
	endtask

	task automatic test_backpressure();
		int n;
		send_idle = 0; recv_idle = 0;
		fork
			begin
				hold_off = 1;
				for (n = 0; n < 1200; n++) @(posedge clk);
				hold_off = 0;
			end
			repeat (6) send_sample($urandom);
		join
		wait_drained();
	endtask

	initial begin
		model_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule

### sample_average_and_running_stats_top.f
src/sarst_pkg.sv
src/sarst_ram.sv
src/sarst_div.sv
src/sarst_sqrt.sv
src/sarst_ctrl.sv
src/sarst_datapath.sv
src/sample_average_and_running_stats_top.sv
tb/sample_average_and_running_stats_top_tb.sv
